### rtl/core/ddc_pkg.sv
// Shared types and constants for the DMA descriptor checker.
`timescale 1ns / 1ps
package ddc_pkg;
  localparam int unsigned NumCounters = 9;

  localparam logic [2:0] OpSubmit   = 3'd0;
  localparam logic [2:0] OpAddHost  = 3'd1;
  localparam logic [2:0] OpAddDev   = 3'd2;
  localparam logic [2:0] OpClear    = 3'd3;
  localparam logic [2:0] OpRead     = 3'd4;

  localparam logic [3:0] ErrNone     = 4'd0;
  localparam logic [3:0] ErrDir      = 4'd1;
  localparam logic [3:0] ErrLength   = 4'd2;
  localparam logic [3:0] ErrFlags    = 4'd3;
  localparam logic [3:0] ErrType     = 4'd4;
  localparam logic [3:0] ErrQ4       = 4'd5;
  localparam logic [3:0] ErrAlign    = 4'd6;
  localparam logic [3:0] ErrOverflow = 4'd7;
  localparam logic [3:0] ErrRange    = 4'd8;
  localparam logic [3:0] ErrOverlap  = 4'd9;

  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StInvalid = 2'd1;
  localparam logic [1:0] StFull    = 2'd2;

  localparam logic [3:0] CntSubmitted = 4'd0;
  localparam logic [3:0] CntFailed    = 4'd1;
  localparam logic [3:0] CntCompleted = 4'd2;
  localparam logic [3:0] CntAlign     = 4'd3;
  localparam logic [3:0] CntRange     = 4'd4;
  localparam logic [3:0] CntFlags     = 4'd5;
  localparam logic [3:0] CntBytesH2d  = 4'd6;

  localparam logic [7:0] DataQ4 = 8'd2;

  // request to the shared range comparator
  typedef struct packed {
    logic [63:0] base;
    logic [63:0] size;
    logic [63:0] addr;
    logic [63:0] len;
  } range_req_t;
endpackage

### rtl/core/ddc_range_unit.sv
// Registered range containment comparator shared by all region scans.
`timescale 1ns / 1ps
module ddc_range_unit (
  input  logic                clk_i,
  input  ddc_pkg::range_req_t req_i,
  output logic                hit_o
);
  import ddc_pkg::*;
  logic [63:0] e, re;
  logic        hit_d, hit_q;
  always_comb begin
    e     = req_i.addr + req_i.len;
    re    = req_i.base + req_i.size;
    hit_d = (req_i.len == 64'd0) ||
            ((req_i.addr >= req_i.base) && (e >= req_i.addr) &&
             (re >= req_i.base) && (e <= re));
  end
  always_ff @(posedge clk_i) begin
    hit_q <= hit_d;
  end
  assign hit_o = hit_q;
endmodule

### rtl/core/dma_descriptor_checker_top.sv
// Top level: descriptor checks, region tables, counters and register port.
// Steps: region ops, clear and read pass check, update, output; a submit that
// passes its checks scans each region entry (issue, wait, evaluate on the one
// range comparator; no wait for an empty table), then update and output.
// One transaction at a time; busy is high from start until the strobe.
// Reset zeroes counters and region counts, presets registers; no clearing pass.
`timescale 1ns / 1ps
module dma_descriptor_checker_top #(
  parameter int unsigned NUM_HOST_RGN = 8,
  parameter int unsigned NUM_DEV_RGN  = 8,
  parameter int unsigned ALIGN_BYTES  = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  output logic        done,
  input  logic [2:0]  operation_i,
  input  logic [7:0]  direction_i,
  input  logic [31:0] byte_length_i,
  input  logic [15:0] flags_i,
  input  logic [7:0]  data_type_i,
  input  logic [7:0]  group_size_i,
  input  logic [63:0] first_address_i,
  input  logic [63:0] second_address_i,
  input  logic [3:0]  counter_select_i,
  output logic [1:0]  status_o,
  output logic [3:0]  error_code_o,
  output logic [63:0] counter_value_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ddc_pkg::*;

  localparam int unsigned HW = $clog2(NUM_HOST_RGN + 1);
  localparam int unsigned DW = $clog2(NUM_DEV_RGN + 1);
  localparam int unsigned HI = (NUM_HOST_RGN > 1) ? $clog2(NUM_HOST_RGN) : 1;
  localparam int unsigned DI = (NUM_DEV_RGN > 1) ? $clog2(NUM_DEV_RGN) : 1;
  localparam int unsigned IW = (HI > DI) ? HI : DI;
  localparam logic [63:0] AlignMask = 64'(ALIGN_BYTES - 1);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_ISSUE = 4'd2;
  localparam logic [3:0] S_WAIT  = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_UPD   = 4'd5;
  localparam logic [3:0] S_OUT   = 4'd6;

  // scan phases: host table with a0, device with a1, device with a0 (d2d)
  localparam logic [1:0] P_HOST  = 2'd0;
  localparam logic [1:0] P_DEV1  = 2'd1;
  localparam logic [1:0] P_DEV0  = 2'd2;

  logic [31:0] max_len_q;
  logic [15:0] flag_mask_q;
  logic        cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q   <= 32'd16777216;
      flag_mask_q <= 16'hFFFF;
    end else if (cfg_wr) begin
      if (paddr == 3'd0) max_len_q <= pwdata;
      else if (paddr == 3'd4) flag_mask_q <= pwdata[15:0];
    end
  end
  always_comb begin
    prdata = 32'd0;
    if (paddr == 3'd0) prdata = max_len_q;
    else if (paddr == 3'd4) prdata = {16'd0, flag_mask_q};
  end

  logic [3:0]  state_q, state_d;
  logic [2:0]  op_q;
  logic [7:0]  dir_q;
  logic [31:0] len_q;
  logic [15:0] flags_q;
  logic [7:0]  dt_q, gs_q;
  logic [63:0] a0_q, a1_q;
  logic [3:0]  sel_q;
  logic [1:0]  status_q;
  logic [3:0]  err_q;
  logic [63:0] val_q;
  logic [1:0]  phase_q;
  logic [IW-1:0] idx_q;
  logic [HW-1:0] hcnt_q;
  logic [DW-1:0] dcnt_q;
  logic [63:0] cnt_q [NumCounters];

  logic [63:0] hbase [NUM_HOST_RGN];
  logic [63:0] hsize [NUM_HOST_RGN];
  logic [63:0] dbase [NUM_DEV_RGN];
  logic [63:0] dsize [NUM_DEV_RGN];
  logic [63:0] rd_base_q, rd_size_q;

  range_req_t req;
  logic       hit;
  ddc_range_unit u_range (.clk_i(clk_i), .req_i(req), .hit_o(hit));

  assign busy = (state_q != S_IDLE);
  assign done = (state_q == S_OUT);
  assign status_o = status_q;
  assign error_code_o = err_q;
  assign counter_value_o = val_q;

  // static checks, evaluated on the latched item
  logic [3:0]  chk_err;
  logic [63:0] l64;
  logic [64:0] s0, s1;
  always_comb begin
    l64 = {32'd0, len_q};
    s0  = {1'b0, a0_q} + {1'b0, l64};
    s1  = {1'b0, a1_q} + {1'b0, l64};
    chk_err = ErrNone;
    if (dir_q > 8'd2) chk_err = ErrDir;
    else if (len_q == 32'd0 || len_q > max_len_q) chk_err = ErrLength;
    else if ((flags_q & ~flag_mask_q) != 16'd0) chk_err = ErrFlags;
    else if (dt_q > 8'd2) chk_err = ErrType;
    else if (dt_q == DataQ4 && gs_q != 8'd32 && gs_q != 8'd64) chk_err = ErrQ4;
    else if (dt_q == DataQ4 && gs_q == 8'd32 && len_q[3:0] != 4'd0) chk_err = ErrQ4;
    else if (dt_q == DataQ4 && gs_q == 8'd64 && len_q[4:0] != 5'd0) chk_err = ErrQ4;
    else if ((a0_q & AlignMask) != 64'd0 || (a1_q & AlignMask) != 64'd0)
      chk_err = ErrAlign;
    else if (s0[64] || s1[64]) chk_err = ErrOverflow;
    else if (dir_q == 8'd2 && !(s0[63:0] <= a1_q || s1[63:0] <= a0_q))
      chk_err = ErrOverlap;
  end

  // phase helpers
  logic         ph_dev;
  logic [IW:0]  ph_n;
  logic [63:0]  ph_addr;
  always_comb begin
    ph_dev  = (phase_q != P_HOST);
    ph_n    = ph_dev ? (IW+1)'(dcnt_q) : (IW+1)'(hcnt_q);
    ph_addr = (phase_q == P_DEV1) ? a1_q : a0_q;
    req.base = rd_base_q;
    req.size = rd_size_q;
    req.addr = ph_addr;
    req.len  = l64;
  end

  always_ff @(posedge clk_i) begin
    if (ph_dev) begin
      rd_base_q <= dbase[idx_q[DI-1:0]];
      rd_size_q <= dsize[idx_q[DI-1:0]];
    end else begin
      rd_base_q <= hbase[idx_q[HI-1:0]];
      rd_size_q <= hsize[idx_q[HI-1:0]];
    end
    if (state_q == S_CHECK && (op_q == OpAddHost || op_q == OpAddDev) &&
        a1_q != 64'd0 && (a0_q & AlignMask) == 64'd0) begin
      if (op_q == OpAddHost && hcnt_q < HW'(NUM_HOST_RGN)) begin
        hbase[hcnt_q[HI-1:0]] <= a0_q;
        hsize[hcnt_q[HI-1:0]] <= a1_q;
      end
      if (op_q == OpAddDev && dcnt_q < DW'(NUM_DEV_RGN)) begin
        dbase[dcnt_q[DI-1:0]] <= a0_q;
        dsize[dcnt_q[DI-1:0]] <= a1_q;
      end
    end
  end

  // next phase after a table passes (or is empty); device with a1 is always last
  logic        nx_done;
  logic [1:0]  nx_phase;
  always_comb begin
    nx_done  = 1'b1;
    nx_phase = P_HOST;
    if (phase_q == P_HOST || phase_q == P_DEV0) begin
      nx_done = 1'b0; nx_phase = P_DEV1;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE:  if (start) state_d = S_CHECK;
      S_CHECK: begin
        if (op_q == OpSubmit && chk_err == ErrNone) state_d = S_ISSUE;
        else state_d = S_UPD;
      end
      S_ISSUE: state_d = (ph_n == '0) ? S_EVAL : S_WAIT;
      S_WAIT:  state_d = S_EVAL;
      S_EVAL:  state_d = (ph_n != '0 && !hit && ({1'b0, idx_q} + 1'b1) >= ph_n) ? S_UPD :
                         (ph_n != '0 && !hit) ? S_ISSUE :
                         nx_done ? S_UPD : S_ISSUE;
      S_UPD:   state_d = S_OUT;
      S_OUT:   state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      hcnt_q   <= '0;
      dcnt_q   <= '0;
      phase_q  <= P_HOST;
      idx_q    <= '0;
      status_q <= StOk;
      err_q    <= ErrNone;
      val_q    <= '0;
      for (int i = 0; i < NumCounters; i++) cnt_q[i] <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: if (start) begin
          phase_q  <= P_HOST;
          idx_q    <= '0;
          status_q <= StOk;
          err_q    <= ErrNone;
          val_q    <= '0;
        end
        S_CHECK: begin
          if (op_q == OpSubmit) begin
            err_q <= chk_err;
            if (dir_q == 8'd2) phase_q <= P_DEV0;
          end else if (op_q == OpAddHost || op_q == OpAddDev) begin
            if (a1_q == 64'd0 || (a0_q & AlignMask) != 64'd0) status_q <= StInvalid;
            else if (op_q == OpAddHost) begin
              if (hcnt_q < HW'(NUM_HOST_RGN)) hcnt_q <= hcnt_q + 1'b1;
              else status_q <= StFull;
            end else begin
              if (dcnt_q < DW'(NUM_DEV_RGN)) dcnt_q <= dcnt_q + 1'b1;
              else status_q <= StFull;
            end
          end else if (op_q == OpRead) begin
            if (sel_q < 4'(NumCounters)) val_q <= cnt_q[sel_q];
            else status_q <= StInvalid;
          end else if (op_q != OpClear) begin
            status_q <= StInvalid;
          end
        end
        S_EVAL: begin
          if (ph_n != '0 && !hit) begin
            if (({1'b0, idx_q} + 1'b1) >= ph_n) err_q <= ErrRange;
            else idx_q <= idx_q + 1'b1;
          end else begin
            idx_q <= '0;
            if (phase_q == P_DEV0) phase_q <= P_DEV1;
            else phase_q <= nx_phase;
          end
        end
        S_UPD: begin
          if (op_q == OpClear) begin
            for (int i = 0; i < NumCounters; i++) cnt_q[i] <= '0;
          end else if (op_q == OpSubmit) begin
            cnt_q[CntSubmitted] <= cnt_q[CntSubmitted] + 64'd1;
            if (err_q != ErrNone) begin
              status_q <= StInvalid;
              cnt_q[CntFailed] <= cnt_q[CntFailed] + 64'd1;
              if (err_q == ErrAlign) cnt_q[CntAlign] <= cnt_q[CntAlign] + 64'd1;
              else if (err_q >= ErrOverflow) cnt_q[CntRange] <= cnt_q[CntRange] + 64'd1;
              else if (err_q == ErrFlags) cnt_q[CntFlags] <= cnt_q[CntFlags] + 64'd1;
            end else begin
              cnt_q[CntCompleted] <= cnt_q[CntCompleted] + 64'd1;
              cnt_q[CntBytesH2d + dir_q[3:0]] <= cnt_q[CntBytesH2d + dir_q[3:0]] + l64;
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && start) begin
      op_q    <= operation_i;
      dir_q   <= direction_i;
      len_q   <= byte_length_i;
      flags_q <= flags_i;
      dt_q    <= data_type_i;
      gs_q    <= group_size_i;
      a0_q    <= first_address_i;
      a1_q    <= second_address_i;
      sel_q   <= counter_select_i;
    end
  end
endmodule

### tb/sv/tb_dma_descriptor_checker_top.sv
// Testbench for the DMA descriptor checker: directed and random transactions with a predictor.
`timescale 1ns / 1ps
module tb_dma_descriptor_checker_top;
  import ddc_pkg::*;

  localparam logic [7:0] DirH2d = 8'd0;
  localparam logic [7:0] DirD2h = 8'd1;
  localparam logic [7:0] DirD2d = 8'd2;
  localparam logic [7:0] DataF32 = 8'd0;
  localparam logic [7:0] DataQ8  = 8'd1;
  localparam logic [2:0] AddrMaxLen   = 3'd0;
  localparam logic [2:0] AddrFlagMask = 3'd4;
  localparam int unsigned Regions = 8;
  localparam logic [63:0] AlignMask = 64'd63;

  typedef struct {
    logic [2:0]  op;
    logic [7:0]  dir;
    logic [31:0] len;
    logic [15:0] flags;
    logic [7:0]  dtype;
    logic [7:0]  gsize;
    logic [63:0] addr0;
    logic [63:0] addr1;
    logic [3:0]  sel;
  } desc_t;

  typedef struct {
    logic [1:0]  status;
    logic [3:0]  err;
    logic [63:0] value;
  } verdict_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start, busy, done;
  logic [2:0]  operation_i;
  logic [7:0]  direction_i;
  logic [31:0] byte_length_i;
  logic [15:0] flags_i;
  logic [7:0]  data_type_i;
  logic [7:0]  group_size_i;
  logic [63:0] first_address_i;
  logic [63:0] second_address_i;
  logic [3:0]  counter_select_i;
  logic [1:0]  status_o;
  logic [3:0]  error_code_o;
  logic [63:0] counter_value_o;
  logic psel, penable, pwrite, pready;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;

  dma_descriptor_checker_top DUT (
    .clk_i, .rst_ni, .start, .busy, .done,
    .operation_i, .direction_i, .byte_length_i, .flags_i, .data_type_i,
    .group_size_i, .first_address_i, .second_address_i, .counter_select_i,
    .status_o, .error_code_o, .counter_value_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow state of the block
  logic [31:0] max_len;
  logic [15:0] flag_mask;
  logic [63:0] host_base [Regions];
  logic [63:0] host_size [Regions];
  logic [63:0] dev_base [Regions];
  logic [63:0] dev_size [Regions];
  int unsigned host_cnt, dev_cnt;
  logic [63:0] stats [NumCounters];

  verdict_t expected_verdicts[$];
  int unsigned error_count = 0;
  int unsigned burst_left = 0;

  function automatic bit range_fits(logic [63:0] rb, logic [63:0] rs, logic [63:0] a,
                                    logic [63:0] len);
    logic [63:0] e, re;
    e = a + len;
    re = rb + rs;
    if (len == 64'd0) return 1'b1;
    if (a < rb || e < a || re < rb) return 1'b0;
    return e <= re;
  endfunction

  function automatic bit in_table(bit is_dev, logic [63:0] a, logic [63:0] len);
    int unsigned n;
    n = is_dev ? dev_cnt : host_cnt;
    for (int unsigned i = 0; i < n; i++) begin
      if (is_dev ? range_fits(dev_base[i], dev_size[i], a, len)
                 : range_fits(host_base[i], host_size[i], a, len)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [3:0] descriptor_error(desc_t d);
    logic [63:0] l;
    l = {32'd0, d.len};
    if (d.dir > DirD2d) return ErrDir;
    if (d.len == 32'd0 || d.len > max_len) return ErrLength;
    if ((d.flags & ~flag_mask) != 16'd0) return ErrFlags;
    if (d.dtype > DataQ4) return ErrType;
    if (d.dtype == DataQ4) begin
      if (d.gsize != 8'd32 && d.gsize != 8'd64) return ErrQ4;
      if (d.len % (d.gsize / 2) != 0) return ErrQ4;
    end
    if ((d.addr0 & AlignMask) != 0 || (d.addr1 & AlignMask) != 0) return ErrAlign;
    if (d.addr0 + l < d.addr0 || d.addr1 + l < d.addr1) return ErrOverflow;
    if (d.dir < DirD2d) begin
      if (host_cnt > 0 && !in_table(1'b0, d.addr0, l)) return ErrRange;
      if (dev_cnt > 0 && !in_table(1'b1, d.addr1, l)) return ErrRange;
    end else begin
      if (!(d.addr0 + l <= d.addr1 || d.addr1 + l <= d.addr0)) return ErrOverlap;
      if (dev_cnt > 0) begin
        if (!in_table(1'b1, d.addr0, l)) return ErrRange;
        if (!in_table(1'b1, d.addr1, l)) return ErrRange;
      end
    end
    return ErrNone;
  endfunction

  function automatic logic [1:0] region_status(int unsigned cnt, desc_t d);
    if (d.addr1 == 64'd0 || (d.addr0 & AlignMask) != 0) return StInvalid;
    if (cnt >= Regions) return StFull;
    return StOk;
  endfunction

  // applies one transaction to the shadow state and returns its result
  function automatic verdict_t apply_descriptor(desc_t d);
    verdict_t v;
    v = '{StOk, ErrNone, 64'd0};
    case (d.op)
      OpSubmit: begin
        stats[CntSubmitted]++;
        v.err = descriptor_error(d);
        if (v.err != ErrNone) begin
          v.status = StInvalid;
          stats[CntFailed]++;
          if (v.err == ErrAlign) stats[CntAlign]++;
          else if (v.err >= ErrOverflow) stats[CntRange]++;
          else if (v.err == ErrFlags) stats[CntFlags]++;
        end else begin
          stats[CntCompleted]++;
          stats[CntBytesH2d + d.dir] += {32'd0, d.len};
        end
      end
      OpAddHost: begin
        v.status = region_status(host_cnt, d);
        if (v.status == StOk) begin
          host_base[host_cnt] = d.addr0;
          host_size[host_cnt] = d.addr1;
          host_cnt++;
        end
      end
      OpAddDev: begin
        v.status = region_status(dev_cnt, d);
        if (v.status == StOk) begin
          dev_base[dev_cnt] = d.addr0;
          dev_size[dev_cnt] = d.addr1;
          dev_cnt++;
        end
      end
      OpClear: for (int i = 0; i < NumCounters; i++) stats[i] = 64'd0;
      OpRead: begin
        if (d.sel < NumCounters) v.value = stats[d.sel];
        else v.status = StInvalid;
      end
      default: v.status = StInvalid;
    endcase
    return v;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    error_count++;
    if (error_count <= 40)
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
  endtask

  always @(posedge clk_i) begin
    verdict_t v;
    if (done) begin
      if (expected_verdicts.size() == 0) begin
        report_mismatch("unexpected result", status_o, 0);
      end else begin
        v = expected_verdicts.pop_front();
        if (status_o !== v.status) report_mismatch("status", status_o, v.status);
        if (error_code_o !== v.err) report_mismatch("error_code", error_code_o, v.err);
        if (counter_value_o !== v.value)
          report_mismatch("counter_value", counter_value_o, v.value);
      end
    end
  end

  // one transaction; the sender works in bursts with random idle gaps between them
  task automatic send_descriptor(desc_t d);
    if (burst_left == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    burst_left--;
    start            <= 1'b1;
    operation_i      <= d.op;
    direction_i      <= d.dir;
    byte_length_i    <= d.len;
    flags_i          <= d.flags;
    data_type_i      <= d.dtype;
    group_size_i     <= d.gsize;
    first_address_i  <= d.addr0;
    second_address_i <= d.addr1;
    counter_select_i <= d.sel;
    do @(posedge clk_i); while (busy);
    expected_verdicts.push_back(apply_descriptor(d));
  endtask

  task automatic drain;
    start <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (expected_verdicts.size() != 0 || busy);
  endtask

  task automatic write_register(logic [2:0] addr, logic [31:0] data);
    drain();
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (addr == AddrMaxLen) max_len = data;
    else flag_mask = data[15:0];
  endtask

  function automatic desc_t plain(logic [2:0] op);
    return '{op, DirH2d, 32'd64, 16'd0, DataF32, 8'd32, 64'd0, 64'd4096, 4'd0};
  endfunction

  function automatic desc_t noise_descriptor();
    desc_t d;
    d.op = $urandom_range(0, 3) == 0 ? 3'($urandom) : OpSubmit;
    d.dir = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 2));
    d.len = $urandom_range(0, 1) ? $urandom : 32'($urandom_range(0, 4096));
    d.flags = 16'($urandom);
    d.dtype = $urandom_range(0, 1) ? 8'($urandom) : 8'($urandom_range(0, 2));
    d.gsize = $urandom_range(0, 1) ? 8'($urandom) : ($urandom_range(0, 1) ? 8'd32 : 8'd64);
    d.addr0 = {$urandom, $urandom};
    d.addr1 = {$urandom, $urandom};
    if ($urandom_range(0, 1)) d.addr0 &= ~AlignMask;
    if ($urandom_range(0, 1)) d.addr1 &= ~AlignMask;
    d.sel = 4'($urandom);
    return d;
  endfunction

  function automatic logic [63:0] address_in(bit is_dev, logic [31:0] len);
    int unsigned n, i;
    logic [63:0] rb, rs;
    n = is_dev ? dev_cnt : host_cnt;
    if (n == 0) return {$urandom, $urandom} & ~AlignMask & 64'h0000_FFFF_FFFF_FFFF;
    i = $urandom_range(0, n - 1);
    rb = is_dev ? dev_base[i] : host_base[i];
    rs = is_dev ? dev_size[i] : host_size[i];
    if (rs <= len) return rb;
    return rb + 64'($urandom_range(0, 32'((rs - len) >> 6))) * 64;
  endfunction

  // well-formed submit with random content, sometimes with one field broken
  function automatic desc_t good_descriptor();
    desc_t d;
    d = plain(OpSubmit);
    d.dir = 8'($urandom_range(0, 2));
    d.dtype = 8'($urandom_range(0, 2));
    d.gsize = $urandom_range(0, 1) ? 8'd32 : 8'd64;
    d.len = 32'($urandom_range(1, 64)) * 32;
    d.flags = 16'($urandom) & flag_mask;
    d.sel = 4'($urandom);
    d.addr0 = address_in(d.dir == DirD2d, d.len);
    d.addr1 = address_in(1'b1, d.len);
    if (d.dir == DirD2d && $urandom_range(0, 2) != 0) d.addr1 = d.addr0 + d.len + 64;
    case ($urandom_range(0, 12))
      0: d.len = d.len + 32'($urandom_range(1, 31));
      1: d.addr0 = d.addr0 + 64'($urandom_range(1, 4096)) * 64;
      2: d.addr1 = d.addr1 - 64'($urandom_range(1, 64)) * 64;
      3: d.flags = 16'($urandom);
      4: d.addr1 = d.addr0 + 64'($urandom_range(0, 7)) * 64;
      default: ;
    endcase
    return d;
  endfunction

  function automatic desc_t region_descriptor();
    desc_t d;
    d = plain($urandom_range(0, 1) ? OpAddHost : OpAddDev);
    d.addr0 = {$urandom, $urandom};
    if ($urandom_range(0, 3) != 0) d.addr0 &= ~AlignMask;
    d.addr1 = $urandom_range(0, 3) == 0 ? 64'd0 : {$urandom, $urandom};
    return d;
  endfunction

  task automatic test_directed;
    desc_t d;
    desc_t list[$];
    d = plain(OpSubmit); d.dir = 8'd3;   list.push_back(d);
    d = plain(OpSubmit); d.dir = 8'd255; list.push_back(d);
    d = plain(OpSubmit); d.len = 32'd0;  list.push_back(d);
    d = plain(OpSubmit); d.len = 32'd16777217; list.push_back(d);
    d = plain(OpSubmit); d.len = 32'hFFFF_FFFF; list.push_back(d);
    d = plain(OpSubmit); d.dtype = 8'd3; list.push_back(d);
    d = plain(OpSubmit); d.dtype = 8'd255; d.flags = 16'hFFFF; list.push_back(d);
    d = plain(OpSubmit); d.dtype = DataQ4; d.gsize = 8'd48; list.push_back(d);
    d = plain(OpSubmit); d.dtype = DataQ4; d.gsize = 8'd64; d.len = 32'd48; list.push_back(d);
    d = plain(OpSubmit); d.dtype = DataQ4; d.gsize = 8'd32; d.len = 32'd48; list.push_back(d);
    d = plain(OpSubmit); d.addr0 = 64'd1; list.push_back(d);
    d = plain(OpSubmit); d.addr1 = 64'h8000_0000_0000_0020; list.push_back(d);
    d = plain(OpSubmit); d.addr0 = 64'hFFFF_FFFF_FFFF_FFC0; d.len = 32'd128; list.push_back(d);
    d = plain(OpSubmit); d.dir = DirD2d; d.addr0 = 64'd0; d.addr1 = 64'd0; list.push_back(d);
    d = plain(OpSubmit); d.dir = DirD2h; d.dtype = DataQ8;
    d.addr0 = 64'hFFFF_FFFF_FFFF_FF80; d.len = 32'd128; list.push_back(d);
    d = plain(OpSubmit); d.dir = DirD2d; d.len = 32'd16777216; d.addr1 = 64'h0100_0000;
    list.push_back(d);
    d = plain(OpAddHost); d.addr1 = 64'd0; list.push_back(d);
    d = plain(OpAddDev);  d.addr0 = 64'd32; list.push_back(d);
    d = plain(OpClear);   list.push_back(d);
    for (int unsigned s = 0; s < 16; s += 5) begin
      d = plain(OpRead); d.sel = 4'(s); list.push_back(d);
    end
    d = plain(3'd5); list.push_back(d);
    d = plain(3'd7); list.push_back(d);
    foreach (list[i]) send_descriptor(list[i]);
    for (int unsigned s = 0; s < NumCounters; s++) begin
      d = plain(OpRead); d.sel = 4'(s); send_descriptor(d);
    end
  endtask

  task automatic test_registers;
    logic [31:0] lens[4] = '{32'd1, 32'hFFFF_FFFF, 32'd4096, 32'd16777216};
    logic [15:0] masks[4] = '{16'h0000, 16'h00F0, 16'h5A5A, 16'hFFFF};
    for (int p = 0; p < 4; p++) begin
      write_register(AddrMaxLen, lens[p]);
      write_register(AddrFlagMask, {16'd0, masks[p]});
      repeat (30) send_descriptor($urandom_range(0, 1) ? noise_descriptor() : good_descriptor());
    end
  endtask

  task automatic test_region_tables;
    desc_t d;
    for (int unsigned i = 0; i <= Regions; i++) begin
      d = plain(OpAddHost);
      // the last host region wraps past the top of the address space
      d.addr0 = (i == Regions - 1) ? 64'hFFFF_FFFF_FFFF_0000 : 64'h1000_0000 * (i + 1);
      d.addr1 = (i == Regions - 1) ? 64'h20000 : 64'h4_0000;
      send_descriptor(d);
      d = plain(OpAddDev);
      d.addr0 = 64'h8_0000_0000 + 64'h100_0000 * i;
      d.addr1 = 64'h4_0000 + 64'h40 * i;
      send_descriptor(d);
    end
  endtask

  task automatic test_random;
    logic [31:0] lens[4] = '{32'hFFFF_FFFF, 32'd1024, 32'd2048, 32'd16777216};
    desc_t d;
    for (int p = 0; p < 4; p++) begin
      write_register(AddrMaxLen, lens[p]);
      write_register(AddrFlagMask, p == 3 ? 32'hFFFF : $urandom);
      repeat (380) begin
        case ($urandom_range(0, 19))
          0, 1, 2: d = noise_descriptor();
          3: d = region_descriptor();
          4, 5: begin d = plain(OpRead); d.sel = 4'($urandom_range(0, 9)); end
          6: d = $urandom_range(0, 3) == 0 ? plain(OpClear) : good_descriptor();
          default: d = good_descriptor();
        endcase
        send_descriptor(d);
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    start <= 1'b0; operation_i <= OpSubmit; direction_i <= '0; byte_length_i <= '0;
    flags_i <= '0; data_type_i <= '0; group_size_i <= '0; first_address_i <= '0;
    second_address_i <= '0; counter_select_i <= '0;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    max_len = 32'd16777216;
    flag_mask = 16'hFFFF;
    host_cnt = 0;
    dev_cnt = 0;
    for (int i = 0; i < NumCounters; i++) stats[i] = 64'd0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_registers();
    test_region_tables();
    test_random();
    drain();
    repeat (40) @(posedge clk_i);
    if (error_count == 0) $display("PASSED: all results match");
    else $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #4ms;
    $display("FAILED: results differ");
    $finish;
  end
endmodule

### sim.f
rtl/core/ddc_pkg.sv
rtl/core/ddc_range_unit.sv
rtl/core/dma_descriptor_checker_top.sv
tb/sv/tb_dma_descriptor_checker_top.sv
